// File: hw/rtl/bpl_pkg.sv
// Shared types and constants for the bounded positional list.
package bpl_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned POS_W        = 8;
    localparam int unsigned COUNT_W      = 9;
    localparam int unsigned CAPACITY_DEF = 16;

    typedef enum logic [2:0] {
        REQ_PUSH_HEAD = 3'd0,
        REQ_PUSH_TAIL = 3'd1,
        REQ_INSERT_AT = 3'd2,
        REQ_POP_HEAD  = 3'd3,
        REQ_POP_TAIL  = 3'd4,
        REQ_REMOVE_AT = 3'd5,
        REQ_PEEK_HEAD = 3'd6,
        REQ_PEEK_TAIL = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic               ins;
        logic               rem;
        logic [COUNT_W-1:0] idx;
        logic [COUNT_W-1:0] rd_idx;
    } t_cell_ctl;

endpackage

// File: hw/rtl/bpl_cell.sv
// One storage cell of the list chain, shifting towards either neighbour.
module bpl_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                                i_clk,
    input  bpl_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [bpl_pkg::DATA_W-1:0]   i_new,
    input  logic signed [bpl_pkg::DATA_W-1:0]   i_left,
    input  logic signed [bpl_pkg::DATA_W-1:0]   i_right,
    output logic signed [bpl_pkg::DATA_W-1:0]   o_val,
    output logic signed [bpl_pkg::DATA_W-1:0]   o_rd
);

    localparam logic [bpl_pkg::COUNT_W-1:0] MyIdx = bpl_pkg::COUNT_W'(IDX);

    logic signed [bpl_pkg::DATA_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (MyIdx == i_ctl.idx) begin
                r_val <= i_new;
            end else if (MyIdx > i_ctl.idx) begin
                r_val <= i_left;
            end
        end else if (i_ctl.rem && (MyIdx >= i_ctl.idx)) begin
            r_val <= i_right;
        end
    end

    assign o_val = r_val;
    assign o_rd  = (MyIdx == i_ctl.rd_idx) ? r_val : '0;

endmodule

// File: hw/rtl/bounded_positional_list_core.sv
// Top level of the bounded positional list: request decode, cell chain and result register.
//
//  Channel  | Valid      | Stall       | Payload
//  ---------+------------+-------------+-------------------------------------
//  request  | i_in_valid | o_in_stall  | i_req_type, i_position, i_value
//  result   | o_out_valid| i_out_stall | o_data_out, o_status, o_count
//
// All cells shift together at the clock edge that accepts the item, and the result is
// loaded into the output register at that same edge.
// A new item is taken each cycle while the result register is empty or being drained.
// Reset clears the count and the result valid flag; cell contents are not reset.
// A stalled result holds, and the request side stalls only while it is held.
module bounded_positional_list_core #(
    parameter int unsigned CAPACITY = bpl_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_req_type,
    input  logic [bpl_pkg::POS_W-1:0]           i_position,
    input  logic signed [bpl_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [bpl_pkg::DATA_W-1:0]   o_data_out,
    output logic [1:0]                          o_status,
    output logic [bpl_pkg::COUNT_W-1:0]         o_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned DW = bpl_pkg::DATA_W;
    localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

    logic [CW-1:0]               r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    logic signed [DW-1:0]        r_data, n_data;
    bpl_pkg::t_status            r_status, n_status;
    logic [bpl_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic                        accept;
    logic                        full, empty;
    logic [bpl_pkg::COUNT_W-1:0] cnt9, pos9, last9;
    bpl_pkg::t_cell_ctl          ctl;
    logic                        ins_ok, rem_ok, rd_ok;
    logic [bpl_pkg::COUNT_W-1:0] idx, rd_idx;
    bpl_pkg::t_status            status;

    logic signed [DW-1:0]        cell_val [CAPACITY];
    logic signed [DW-1:0]        cell_rd  [CAPACITY];
    logic [CAPACITY-1:0]         rd_col   [DW];
    logic signed [DW-1:0]        rd_val;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CapVal);
    assign empty = (r_count == '0);
    assign cnt9  = bpl_pkg::COUNT_W'(r_count);
    assign pos9  = bpl_pkg::COUNT_W'(i_position);
    assign last9 = cnt9 - bpl_pkg::COUNT_W'(1);

    always_comb begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        rd_ok  = 1'b0;
        idx    = '0;
        rd_idx = '0;
        status = bpl_pkg::ST_OK;
        unique case (bpl_pkg::t_req'(i_req_type))
            bpl_pkg::REQ_PUSH_HEAD, bpl_pkg::REQ_PUSH_TAIL, bpl_pkg::REQ_INSERT_AT: begin
                if (full) begin
                    status = bpl_pkg::ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                    if (bpl_pkg::t_req'(i_req_type) == bpl_pkg::REQ_PUSH_HEAD) begin
                        idx = '0;
                    end else if (bpl_pkg::t_req'(i_req_type) == bpl_pkg::REQ_PUSH_TAIL
                                 || pos9 >= cnt9) begin
                        idx = cnt9;
                    end else begin
                        idx = pos9;
                    end
                end
            end
            bpl_pkg::REQ_POP_HEAD, bpl_pkg::REQ_POP_TAIL, bpl_pkg::REQ_REMOVE_AT: begin
                if (empty) begin
                    status = bpl_pkg::ST_EMPTY;
                end else if (bpl_pkg::t_req'(i_req_type) == bpl_pkg::REQ_REMOVE_AT
                             && pos9 >= cnt9) begin
                    status = bpl_pkg::ST_RANGE;
                end else begin
                    rem_ok = 1'b1;
                    rd_ok  = 1'b1;
                    if (bpl_pkg::t_req'(i_req_type) == bpl_pkg::REQ_POP_HEAD) begin
                        idx = '0;
                    end else if (bpl_pkg::t_req'(i_req_type) == bpl_pkg::REQ_POP_TAIL) begin
                        idx = last9;
                    end else begin
                        idx = pos9;
                    end
                    rd_idx = idx;
                end
            end
            bpl_pkg::REQ_PEEK_HEAD, bpl_pkg::REQ_PEEK_TAIL: begin
                if (empty) begin
                    status = bpl_pkg::ST_EMPTY;
                end else begin
                    rd_ok  = 1'b1;
                    rd_idx = (bpl_pkg::t_req'(i_req_type) == bpl_pkg::REQ_PEEK_HEAD)
                             ? '0 : last9;
                end
            end
            default: begin
                status = bpl_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        ctl.ins    = accept && ins_ok;
        ctl.rem    = accept && rem_ok;
        ctl.idx    = idx;
        ctl.rd_idx = rd_idx;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DW-1:0] left_val, right_val;
        if (g == 0) begin : g_first
            assign left_val = i_value;
        end else begin : g_mid
            assign left_val = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = cell_val[g+1];
        end
        bpl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_new   (i_value),
            .i_left  (left_val),
            .i_right (right_val),
            .o_val   (cell_val[g]),
            .o_rd    (cell_rd[g])
        );
        for (genvar b = 0; b < DW; b++) begin : g_bit
            assign rd_col[b][g] = cell_rd[g][b];
        end
    end

    for (genvar b = 0; b < DW; b++) begin : g_rd
        assign rd_val[b] = |rd_col[b];
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_data      = r_data;
        n_status    = r_status;
        n_out_count = r_out_count;
        if (accept) begin
            if (ins_ok) begin
                n_count = r_count + CW'(1);
            end else if (rem_ok) begin
                n_count = r_count - CW'(1);
            end
            n_out_valid = 1'b1;
            n_data      = rd_ok ? rd_val : '0;
            n_status    = status;
            n_out_count = bpl_pkg::COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data      <= n_data;
        r_status    <= n_status;
        r_out_count <= n_out_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data;
    assign o_status    = r_status;
    assign o_count     = r_out_count;

endmodule
